FILE: hw/rtl/bfds_pkg.sv
// Package for the byte FIFO with drop statistics.
// Holds the transaction structs, the controller/datapath command and status
// structs, and the mode codes. No dependencies.
package bfds_pkg;

   localparam int DATA_W  = 8;
   localparam int LEN_W   = 7;
   localparam int OCC_W   = 8;
   localparam int COUNT_W = 32;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [DATA_W-1:0] data_in;
      logic [LEN_W-1:0]  burst_length;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  data_out;
      logic               has_data;
      logic               last;
      logic               push_accepted;
      logic [OCC_W-1:0]   occupancy;
      logic [COUNT_W-1:0] pushed_total;
      logic [COUNT_W-1:0] dropped_total;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push;        // accept a push transaction
      logic read_start;  // accept a read transaction
      logic emit;        // move one stored byte to the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;     // output register can be loaded at this edge
      logic burst_empty;  // the offered read would return no bytes
      logic last_byte;    // the byte being emitted ends the burst
   } sts_type;

endpackage

FILE: hw/rtl/bfds_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bfds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bfds_ctrl.sv
// Controller state machine for the byte FIFO with drop statistics.
// Depends on bfds_pkg for the command and status structs and mode codes.
module bfds_ctrl import bfds_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_mode,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_BURST = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign accept = (state_ff == ST_IDLE) && req_valid && sts.out_free;

   always_comb begin
      state_in       = state_ff;
      cmd.push       = 1'b0;
      cmd.read_start = 1'b0;
      cmd.emit       = 1'b0;
      req_stall      = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !sts.out_free;
            if (accept) begin
               if (req_mode == MODE_PUSH) begin
                  cmd.push = 1'b1;
               end else begin
                  cmd.read_start = 1'b1;
                  if (!sts.burst_empty) begin
                     state_in = ST_BURST;
                  end
               end
            end
         end
         ST_BURST: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.last_byte) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/bfds_dp.sv
// Datapath for the byte FIFO with drop statistics: indices, counters,
// burst counter, byte store and the output register.
// Depends on bfds_pkg and bfds_ram.
module bfds_dp import bfds_pkg::*; #(
   parameter int DEPTH     = 256,
   parameter int MAX_BURST = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_payload,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PAD_W   = (IDX_W > OCC_W) ? IDX_W : OCC_W;
   localparam int CMP_W   = (IDX_W > LEN_W) ? IDX_W : LEN_W;
   localparam int BURST_W = $clog2(MAX_BURST + 1);

   logic [IDX_W-1:0]   write_idx_ff, write_idx_in;
   logic [IDX_W-1:0]   read_idx_ff, read_idx_in;
   logic [COUNT_W-1:0] pushed_ff, pushed_in;
   logic [COUNT_W-1:0] dropped_ff, dropped_in;
   logic [BURST_W-1:0] remain_ff, remain_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [IDX_W-1:0]   occ_now;
   logic [IDX_W-1:0]   occ_next;
   logic [PAD_W-1:0]   occ_pad;
   logic               full;
   logic [LEN_W-1:0]   len_sat;
   logic [CMP_W-1:0]   burst_n;
   logic               load;
   logic               store_wr;
   logic [DATA_W-1:0]  store_rd_data;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == IDX_W'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + 1'b1;
      end
      return res;
   endfunction

   function automatic logic [IDX_W-1:0] used(input logic [IDX_W-1:0] w,
                                             input logic [IDX_W-1:0] r);
      logic [IDX_W:0] sum;
      if (w >= r) begin
         sum = {1'b0, w} - {1'b0, r};
      end else begin
         sum = {1'b0, w} + (IDX_W + 1)'(DEPTH) - {1'b0, r};
      end
      return sum[IDX_W-1:0];
   endfunction

   assign occ_now  = used(write_idx_ff, read_idx_ff);
   assign full     = (occ_now == IDX_W'(DEPTH - 1));
   assign len_sat  = (req_payload.burst_length > LEN_W'(MAX_BURST)) ?
                     LEN_W'(MAX_BURST) : req_payload.burst_length;
   assign burst_n  = (CMP_W'(len_sat) < CMP_W'(occ_now)) ?
                     CMP_W'(len_sat) : CMP_W'(occ_now);
   assign store_wr = cmd.push && !full;

   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;
   assign sts.burst_empty = (burst_n == '0);
   assign sts.last_byte   = (remain_ff == BURST_W'(1));

   always_comb begin
      write_idx_in = write_idx_ff;
      read_idx_in  = read_idx_ff;
      pushed_in    = pushed_ff;
      dropped_in   = dropped_ff;
      remain_in    = remain_ff;
      if (cmd.push) begin
         if (full) begin
            dropped_in = dropped_ff + 1'b1;
         end else begin
            write_idx_in = wrap_inc(write_idx_ff);
            pushed_in    = pushed_ff + 1'b1;
         end
      end
      if (cmd.read_start) begin
         remain_in = BURST_W'(burst_n);
      end
      if (cmd.emit) begin
         read_idx_in = wrap_inc(read_idx_ff);
         remain_in   = remain_ff - 1'b1;
      end
   end

   assign occ_next = used(write_idx_in, read_idx_in);
   assign occ_pad  = PAD_W'(occ_next);
   assign load     = cmd.push || cmd.emit || (cmd.read_start && sts.burst_empty);

   always_comb begin
      rsp_in.data_out      = cmd.emit ? store_rd_data : '0;
      rsp_in.has_data      = cmd.emit;
      rsp_in.last          = cmd.emit ? sts.last_byte : 1'b1;
      rsp_in.push_accepted = store_wr;
      rsp_in.occupancy     = occ_pad[OCC_W-1:0];
      rsp_in.pushed_total  = pushed_in;
      rsp_in.dropped_total = dropped_in;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_idx_ff <= '0;
         read_idx_ff  <= '0;
         pushed_ff    <= '0;
         dropped_ff   <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         write_idx_ff <= write_idx_in;
         read_idx_ff  <= read_idx_in;
         pushed_ff    <= pushed_in;
         dropped_ff   <= dropped_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // The read port follows the next read index, so the registered read data
   // always holds the oldest byte once the index has settled.
   bfds_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (store_wr),
      .wr_addr(write_idx_ff),
      .wr_data(req_payload.data_in),
      .rd_addr(read_idx_in),
      .rd_data(store_rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hw/rtl/byte_fifo_with_drop_stats_core.sv
// Top level of the byte FIFO with drop statistics.
// Depends on bfds_pkg, bfds_ctrl, bfds_dp and bfds_ram.
//
// A circular byte FIFO of DEPTH slots that keeps one slot empty, so it holds
// at most DEPTH-1 bytes. Each request transaction either pushes one byte or
// reads a burst of up to burst_length bytes (saturated to MAX_BURST). A push
// into a full FIFO drops the byte and increments the dropped count. A read
// returns one response transaction per byte, oldest first, with last set on
// the final one; a read of an empty FIFO or of zero length returns a single
// response with no data. Every response carries the occupancy after its step
// (low 8 bits) and the 32-bit pushed and dropped totals, which wrap. Timing:
// a push, and a read that returns no data, leave the controller idle, so the
// next request can be taken in the following cycle. A read of n bytes holds
// off requests until its last byte has moved, while one byte a cycle moves
// from the byte store to the output register unless responses stall; the
// store's single read port sets that pace. Response stalls pause the block,
// since the output register is loaded only when it is empty or being emptied.
// The byte store is a RAM without reset and needs no clearing after reset.
module byte_fifo_with_drop_stats_core import bfds_pkg::*; #(
   parameter int DEPTH     = 256,
   parameter int MAX_BURST = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type cmd;
   sts_type sts;

   // The controller decides when a transaction is taken and when a byte moves.
   bfds_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_mode (req_payload.mode),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   // The datapath holds the indices, counters, byte store and output register.
   bfds_dp #(
      .DEPTH    (DEPTH),
      .MAX_BURST(MAX_BURST)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule
